### rtl/core/rpa_pkg.sv
// Shared types and constants for the RGBA pixel ALU.
package rpa_pkg;

    localparam int NUM_CH     = 3;
    localparam int CH_W       = 8;
    localparam int COLOR_W    = 32;
    localparam int SCALAR_W   = 16;
    localparam int DIV_W      = SCALAR_W - 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CH_W-1:0] CH_MAX            = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA_RESET       = 8'hFF;
    localparam logic            REG_DEFAULT_ALPHA = 1'b0;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_MOD   = 4'd2,
        CMD_SCALE = 4'd3,
        CMD_DIV   = 4'd4,
        CMD_OR    = 4'd5,
        CMD_AND   = 4'd6,
        CMD_XOR   = 4'd7,
        CMD_INV   = 4'd8
    } t_cmd;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_chans;

    typedef struct packed {
        logic [3:0]                    cmd;
        logic                          black;
        logic                          eq;
        logic [CH_W-1:0]               alpha;
        t_chans                        quick;
        logic [NUM_CH-1:0][2*CH_W-1:0] prod;
        t_chans                        modr;
        t_chans                        dvd;
        logic [DIV_W-1:0]              dvs;
        t_chans                        rem;
        t_chans                        quo;
    } t_stage;

endpackage

### rtl/core/rpa_if.sv
// Valid/ready channel interfaces for the pixel ALU input and result streams.
interface rpa_in_if;
    logic                       valid;
    logic                       ready;
    logic [3:0]                 cmd;
    logic [31:0]                first_color;
    logic [31:0]                other_color;
    logic signed [15:0]         scalar;

    modport source (output valid, cmd, first_color, other_color, scalar, input ready);
    modport sink   (input valid, cmd, first_color, other_color, scalar, output ready);
endinterface

interface rpa_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_color;
    logic        rgb_equal;

    modport source (output valid, result_color, rgb_equal, input ready);
    modport sink   (input valid, result_color, rgb_equal, output ready);
endinterface

### rtl/core/rpa_cfg.sv
// APB-style register port holding the default alpha register.
module rpa_cfg import rpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CH_W-1:0]       o_default_alpha
);

    logic [CH_W-1:0] r_default_alpha;
    logic            w_hit;

    assign pready = 1'b1;
    assign w_hit  = (paddr[CFG_ADDR_W-1] == REG_DEFAULT_ALPHA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_alpha <= ALPHA_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_default_alpha <= pwdata[CH_W-1:0];
        end
    end

    assign prdata          = w_hit ? {{(CFG_DATA_W-CH_W){1'b0}}, r_default_alpha} : '0;
    assign o_default_alpha = r_default_alpha;

endmodule

### rtl/core/rpa_div2.sv
// Two restoring division steps on one 8-bit channel.
module rpa_div2 import rpa_pkg::*; (
    input  logic [CH_W-1:0]  i_rem,
    input  logic [1:0]       i_bits,
    input  logic [DIV_W-1:0] i_divisor,
    output logic [CH_W-1:0]  o_rem,
    output logic [1:0]       o_q
);

    always_comb begin
        logic [CH_W:0]   t;
        logic [CH_W-1:0] r;
        logic [1:0]      q;
        r = i_rem;
        q = '0;
        for (int k = 1; k >= 0; k--) begin
            t = {r, i_bits[k]};
            // partial remainder never exceeds the dividend, so 8 bits hold it
            if ({{(DIV_W-CH_W-1){1'b0}}, t} >= i_divisor) begin
                q[k] = 1'b1;
                r    = CH_W'({{(DIV_W-CH_W-1){1'b0}}, t} - i_divisor);
            end else begin
                r    = t[CH_W-1:0];
            end
        end
        o_rem = r;
        o_q   = q;
    end

endmodule

### rtl/core/rgba_pixel_alu_unit.sv
// Top level of the RGBA8888 pixel ALU: four-stage pipeline and register port.
//
// Usage: items arrive on i_in (cmd, first_color, other_color, scalar) and are
// transferred when valid and ready are both high. Each item gives exactly one
// result on o_out (result_color, rgb_equal), in input order.
// Pipeline: each item passes three pipeline stages plus the output register;
// the channel divide is spread over those four stages, two quotient bits
// per stage.
// Throughput: one item per clock when o_out.ready stays high.
// Configuration: default_alpha, byte address 0 of the APB-style port, reads
// back on prdata; user writes only while the pipeline is empty (unenforced).
// Reset (synchronous, active low): all stage valid bits clear, the output
// goes invalid and default_alpha returns to 255.
// Stall: while o_out.ready is low the output holds its result; stages behind
// it keep advancing into empty slots, and i_in.ready drops only once every
// stage holds an item.
module rgba_pixel_alu_unit import rpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rpa_in_if.sink                i_in,
    rpa_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CH_W-1:0] w_default_alpha;

    rpa_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_default_alpha (w_default_alpha)
    );

    t_stage r_s1, r_s2, r_s3;
    t_stage n_s1, n_s2, n_s3;
    logic   r_v1, r_v2, r_v3, r_out_valid;
    logic   en1, en2, en3, en_out;

    logic [COLOR_W-1:0] r_out_color, n_out_color;
    logic               r_out_eq;

    t_chans              w_a, w_b;
    t_chans              w_rem1, w_rem2, w_rem3, w_rem4;
    logic [NUM_CH-1:0][1:0] w_q1, w_q2, w_q3, w_q4;

    // advance a stage when it is empty or the next one advances
    assign en_out     = !r_out_valid || o_out.ready;
    assign en3        = !r_v3 || en_out;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign i_in.ready = en1;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_a[c] = i_in.first_color[CH_W*(c+1) +: CH_W];
            w_b[c] = i_in.other_color[CH_W*(c+1) +: CH_W];
        end
    end

    for (genvar g_ch = 0; g_ch < NUM_CH; g_ch++) begin : g_div
        rpa_div2 u_d1 (
            .i_rem     ('0),
            .i_bits    (w_a[g_ch][7:6]),
            .i_divisor (i_in.scalar[DIV_W-1:0]),
            .o_rem     (w_rem1[g_ch]),
            .o_q       (w_q1[g_ch])
        );
        rpa_div2 u_d2 (
            .i_rem     (r_s1.rem[g_ch]),
            .i_bits    (r_s1.dvd[g_ch][5:4]),
            .i_divisor (r_s1.dvs),
            .o_rem     (w_rem2[g_ch]),
            .o_q       (w_q2[g_ch])
        );
        rpa_div2 u_d3 (
            .i_rem     (r_s2.rem[g_ch]),
            .i_bits    (r_s2.dvd[g_ch][3:2]),
            .i_divisor (r_s2.dvs),
            .o_rem     (w_rem3[g_ch]),
            .o_q       (w_q3[g_ch])
        );
        rpa_div2 u_d4 (
            .i_rem     (r_s3.rem[g_ch]),
            .i_bits    (r_s3.dvd[g_ch][1:0]),
            .i_divisor (r_s3.dvs),
            .o_rem     (w_rem4[g_ch]),
            .o_q       (w_q4[g_ch])
        );
    end

    // stage 1: simple ops, products, first two quotient bits
    always_comb begin
        logic [CH_W:0]     sum;
        logic [2*CH_W-1:0] sprod;
        logic              positive;
        positive      = (i_in.scalar != '0) && !i_in.scalar[SCALAR_W-1];
        n_s1          = '0;
        n_s1.cmd      = i_in.cmd;
        n_s1.black    = ((i_in.cmd == CMD_SCALE) || (i_in.cmd == CMD_DIV)) && !positive;
        n_s1.eq       = (i_in.first_color[COLOR_W-1:CH_W] == i_in.other_color[COLOR_W-1:CH_W]);
        n_s1.alpha    = i_in.first_color[CH_W-1:0];
        n_s1.dvs      = i_in.scalar[DIV_W-1:0];
        for (int c = 0; c < NUM_CH; c++) begin
            sum          = {1'b0, w_a[c]} + {1'b0, w_b[c]};
            sprod        = w_a[c] * i_in.scalar[CH_W-1:0];
            n_s1.prod[c] = w_a[c] * w_b[c];
            n_s1.dvd[c]  = w_a[c];
            n_s1.rem[c]  = w_rem1[c];
            n_s1.quo[c]  = {w_q1[c], 6'b0};
            case (i_in.cmd)
                CMD_ADD:   n_s1.quick[c] = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
                CMD_SUB:   n_s1.quick[c] = (w_b[c] < w_a[c]) ? (w_a[c] - w_b[c]) : '0;
                CMD_SCALE: n_s1.quick[c] = sprod[CH_W-1:0];
                CMD_OR:    n_s1.quick[c] = w_a[c] | w_b[c];
                CMD_AND:   n_s1.quick[c] = w_a[c] & w_b[c];
                CMD_XOR:   n_s1.quick[c] = w_a[c] ^ w_b[c];
                CMD_INV:   n_s1.quick[c] = w_a[c] ^ CH_MAX;
                default:   n_s1.quick[c] = w_a[c];
            endcase
        end
    end

    // stage 2: divide product by 255 (reciprocal form), next two quotient bits
    always_comb begin
        logic [2*CH_W:0] acc;
        n_s2 = r_s1;
        for (int c = 0; c < NUM_CH; c++) begin
            acc          = {1'b0, r_s1.prod[c]} + {{(CH_W+1){1'b0}}, r_s1.prod[c][2*CH_W-1:CH_W]}
                           + (2*CH_W+1)'(1);
            n_s2.modr[c] = acc[2*CH_W-1:CH_W];
            n_s2.rem[c]  = w_rem2[c];
            n_s2.quo[c]  = {r_s1.quo[c][7:6], w_q2[c], 4'b0};
        end
    end

    always_comb begin
        n_s3 = r_s2;
        for (int c = 0; c < NUM_CH; c++) begin
            n_s3.rem[c] = w_rem3[c];
            n_s3.quo[c] = {r_s2.quo[c][7:4], w_q3[c], 2'b0};
        end
    end

    // output stage: last quotient bits and channel select
    always_comb begin
        logic [CH_W-1:0] v;
        n_out_color = {{(COLOR_W-CH_W){1'b0}}, r_s3.alpha};
        for (int c = 0; c < NUM_CH; c++) begin
            case (r_s3.cmd)
                CMD_MOD: v = r_s3.modr[c];
                CMD_DIV: v = {r_s3.quo[c][7:2], w_q4[c]};
                default: v = r_s3.quick[c];
            endcase
            n_out_color[CH_W*(c+1) +: CH_W] = v;
        end
        if (r_s3.black) begin
            n_out_color = {{(COLOR_W-CH_W){1'b0}}, w_default_alpha};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en_out) begin
                r_out_valid <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
        if (en3) begin
            r_s3 <= n_s3;
        end
        if (en_out) begin
            r_out_color <= n_out_color;
            r_out_eq    <= r_s3.eq;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_color = r_out_color;
    assign o_out.rgb_equal    = r_out_eq;

endmodule

### dv/rgba_pixel_alu_checker.sv
// Scoreboard for the RGBA pixel ALU: predicts each result and compares it with the output stream.
module rgba_pixel_alu_checker import rpa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rpa_in_if                     i_in,
    rpa_out_if                    i_out,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    input  logic [CFG_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               eq;
    } t_pixel_result;

    logic [CH_W-1:0] alpha_reg;
    t_pixel_result   expected_pixels[$];
    int              accepted_items;
    int              delivered_results;

    assign o_pending = accepted_items - delivered_results;

    function automatic t_pixel_result compute_pixel(
        input logic [3:0]          cmd,
        input logic [COLOR_W-1:0]  c1,
        input logic [COLOR_W-1:0]  c2,
        input logic signed [15:0]  k,
        input logic [CH_W-1:0]     alpha
    );
        t_pixel_result   r;
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        logic [CH_W-1:0] v;
        logic [31:0]     wide;
        r.eq = (c1[COLOR_W-1:CH_W] == c2[COLOR_W-1:CH_W]);
        if ((cmd == CMD_SCALE || cmd == CMD_DIV) && !(k > 0)) begin
            // non-positive scalar: black with the programmed alpha
            r.color = {{(COLOR_W-CH_W){1'b0}}, alpha};
        end else begin
            r.color = c1;
            for (int ch = 1; ch <= NUM_CH; ch++) begin
                a = c1[CH_W*ch +: CH_W];
                b = c2[CH_W*ch +: CH_W];
                case (cmd)
                    CMD_ADD: begin
                        wide = a + b;
                        v = (wide > CH_MAX) ? CH_MAX : wide[CH_W-1:0];
                    end
                    CMD_SUB: v = (b < a) ? a - b : '0;
                    CMD_MOD: begin
                        wide = a * b;
                        wide = wide / CH_MAX;
                        v = wide[CH_W-1:0];
                    end
                    CMD_SCALE: begin
                        wide = a * k[14:0];
                        v = wide[CH_W-1:0];
                    end
                    CMD_DIV: begin
                        wide = a / k[14:0];
                        v = wide[CH_W-1:0];
                    end
                    CMD_OR:  v = a | b;
                    CMD_AND: v = a & b;
                    CMD_XOR: v = a ^ b;
                    CMD_INV: v = a ^ CH_MAX;
                    default: v = a;
                endcase
                r.color[CH_W*ch +: CH_W] = v;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel_result want;
        int            bad;
        bad = 0;
        if (!i_rst_n) begin
            alpha_reg = ALPHA_RESET;
            expected_pixels.delete();
            accepted_items <= 0;
            delivered_results <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pready
                    && i_paddr[CFG_ADDR_W-1:2] == REG_DEFAULT_ALPHA) begin
                if (i_pwrite) begin
                    alpha_reg = i_pwdata[CH_W-1:0];
                end else if (i_prdata !== CFG_DATA_W'(alpha_reg)) begin
                    $error("prdata mismatch: expected %h, actual %h",
                           CFG_DATA_W'(alpha_reg), i_prdata);
                    bad++;
                end
            end
            // check the outgoing transfer before queueing the incoming one
            if (i_out.valid && i_out.ready) begin
                delivered_results <= delivered_results + 1;
                if (expected_pixels.size() == 0) begin
                    $error("result_color %h arrived with no result expected",
                           i_out.result_color);
                    bad++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out.result_color !== want.color) begin
                        $error("result_color mismatch: expected %h, actual %h",
                               want.color, i_out.result_color);
                        bad++;
                    end
                    if (i_out.rgb_equal !== want.eq) begin
                        $error("rgb_equal mismatch: expected %b, actual %b",
                               want.eq, i_out.rgb_equal);
                        bad++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_pixels.push_back(compute_pixel(i_in.cmd, i_in.first_color,
                                          i_in.other_color, i_in.scalar, alpha_reg));
                accepted_items <= accepted_items + 1;
            end
            o_fail_count <= o_fail_count + bad;
        end
    end

endmodule

### dv/tb_rgba_pixel_alu_unit.sv
// Testbench top for the RGBA pixel ALU: stimulus, flow control, register setup and verdict.
module tb_rgba_pixel_alu_unit;
    import rpa_pkg::*;

    localparam int RANDOM_ITEMS   = 830;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = RANDOM_ITEMS / PHASES;
    localparam int CALM_ITEMS     = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 500;

    localparam logic [CFG_ADDR_W-1:0] ADDR_DEFAULT_ALPHA = CFG_ADDR_W'(REG_DEFAULT_ALPHA) << 2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED      = CFG_ADDR_W'(4);
    localparam logic [3:0]            CMD_UNUSED_LO      = 4'd9;
    localparam logic [3:0]            CMD_UNUSED_HI      = 4'd15;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    bit                    calm;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles = 0;

    rpa_in_if  in_ch();
    rpa_out_if out_ch();

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    rgba_pixel_alu_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rgba_pixel_alu_checker pixel_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Optional idle burst, then hold the item until the transfer.
    task automatic send_pixel(input logic [3:0] cmd, input logic [COLOR_W-1:0] c1,
                              input logic [COLOR_W-1:0] c2, input logic [15:0] k);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.first_color <= c1;
        in_ch.other_color <= c2;
        in_ch.scalar      <= k;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop sending and wait until every predicted result has been delivered.
    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] boundary_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            default: return 8'hFE;
        endcase
    endfunction

    // Receiver: random stall bursts, none once the run turns calm.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [3:0]         cmd;
        logic [COLOR_W-1:0] c1;
        logic [COLOR_W-1:0] c2;
        logic [15:0]        k;
        logic [CH_W-1:0]    alpha;
        calm = 1'b0;
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_ADD;
        in_ch.first_color <= '0;
        in_ch.other_color <= '0;
        in_ch.scalar      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // read back the reset value of default_alpha
        apb_access(1'b0, ADDR_DEFAULT_ALPHA, '0);

        // directed corners with default_alpha at its reset value
        send_pixel(CMD_ADD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        send_pixel(CMD_ADD,   32'h807F_0012, 32'h7F81_0034, 16'h8000);
        send_pixel(CMD_SUB,   32'h8010_00AA, 32'h7F10_FF55, 16'h7FFF);
        send_pixel(CMD_SUB,   32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        send_pixel(CMD_MOD,   32'hFFFF_FF01, 32'hFFFF_FF02, 16'h0000);
        send_pixel(CMD_MOD,   32'hFE01_8000, 32'hFFFE_80FF, 16'h8000);
        send_pixel(CMD_SCALE, 32'hFF80_015A, 32'h1234_5678, 16'h0001);
        send_pixel(CMD_SCALE, 32'hFF80_035A, 32'h0000_0000, 16'h7FFF);
        send_pixel(CMD_SCALE, 32'h0280_FF00, 32'hFFFF_FFFF, 16'h0101);
        send_pixel(CMD_SCALE, 32'h1122_3344, 32'h1122_3344, 16'h0000);
        send_pixel(CMD_SCALE, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
        send_pixel(CMD_DIV,   32'hFF80_07C3, 32'hFFFF_FFFF, 16'h0001);
        send_pixel(CMD_DIV,   32'hFF80_07C3, 32'h0000_0000, 16'h0002);
        send_pixel(CMD_DIV,   32'hFFFF_FF3C, 32'h0000_0000, 16'h7FFF);
        send_pixel(CMD_DIV,   32'hFFFE_FD11, 32'h0000_0000, 16'h0100);
        send_pixel(CMD_DIV,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000);
        send_pixel(CMD_DIV,   32'h1020_3040, 32'h1020_3040, 16'h0000);
        send_pixel(CMD_OR,    32'hF00F_AA11, 32'h0F0F_5522, 16'h8000);
        send_pixel(CMD_AND,   32'hF00F_AA11, 32'h0F0F_5522, 16'h7FFF);
        send_pixel(CMD_XOR,   32'hF00F_AA11, 32'h0F0F_5522, 16'h0000);
        send_pixel(CMD_INV,   32'h00FF_5A7E, 32'hFFFF_FFFF, 16'h0005);
        send_pixel(CMD_UNUSED_LO, 32'h1234_5678, 32'h8765_4321, 16'h0003);
        send_pixel(CMD_UNUSED_HI, 32'hCAFE_BABE, 32'h0000_0000, 16'hFFFF);
        send_pixel(CMD_XOR,   32'hABCD_EF00, 32'hABCD_EFFF, 16'h0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_pipeline();
            case (phase)
                0:       alpha = '0;
                1:       alpha = CH_MAX;
                default: alpha = CH_W'($urandom());
            endcase
            apb_access(1'b1, ADDR_DEFAULT_ALPHA, {24'($urandom()), alpha});
            apb_access(1'b1, ADDR_UNMAPPED, $urandom());
            apb_access(1'b0, ADDR_DEFAULT_ALPHA, '0);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                calm = (phase == PHASES - 1) && (n >= PHASE_ITEMS - CALM_ITEMS);
                if ($urandom_range(0, 11) == 0)
                    cmd = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                else
                    cmd = 4'($urandom_range(CMD_ADD, CMD_INV));
                c1 = $urandom();
                c2 = $urandom();
                case ($urandom_range(0, 7))
                    0: c2 = {c1[COLOR_W-1:CH_W], CH_W'($urandom())};
                    1: begin
                        for (int ch = 1; ch <= NUM_CH; ch++) begin
                            c1[CH_W*ch +: CH_W] = boundary_byte();
                            c2[CH_W*ch +: CH_W] = boundary_byte();
                        end
                    end
                    default: ;
                endcase
                case ($urandom_range(0, 5))
                    0:       k = 16'h8000 | 16'($urandom());
                    1:       k = '0;
                    2:       k = 16'($urandom_range(1, 9));
                    3:       k = 16'($urandom_range(200, 300));
                    default: k = 16'($urandom());
                endcase
                send_pixel(cmd, c1, c2, k);
            end
        end
        drain_pipeline();

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### rgba_pixel_alu_unit.f
rtl/core/rpa_pkg.sv
rtl/core/rpa_if.sv
rtl/core/rpa_cfg.sv
rtl/core/rpa_div2.sv
rtl/core/rgba_pixel_alu_unit.sv
dv/rgba_pixel_alu_checker.sv
dv/tb_rgba_pixel_alu_unit.sv
